FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the demultiplexer core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle
`define SFD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// types, codes and constants shared by the sector frame demultiplexer
// ----------------------------------------------------------------------------
package sfd_pkg;

   localparam int AUDIO_BYTES_DEFAULT    = 400;
   localparam int LIGHT_BYTES_DEFAULT    = 64;
   localparam int SMOKE_BYTES_DEFAULT    = 8;
   localparam int RESERVED_BYTES_DEFAULT = 33;
   localparam int BLOCK_BYTES            = 512;

   localparam logic [7:0]  DATA_TOKEN        = 8'hFE;
   localparam logic [7:0]  IDLE_BYTE         = 8'hFF;
   localparam logic [31:0] END_HEADER        = 32'hFFFF_FFFF;
   localparam logic [15:0] WAIT_LIMIT_RESET  = 16'd30000;
   localparam logic [31:0] START_ADDR_RESET  = 32'd0;

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HEADER_WORD  = 3'd0,
      CSR_TRAILER_WORD = 3'd1,
      CSR_BYTE_ADDR    = 3'd2,
      CSR_WAIT_LIMIT   = 3'd3,
      CSR_START_ADDR   = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_HUNT  = 4'd0,
      PH_HEAD  = 4'd1,
      PH_AUDIO = 4'd2,
      PH_LIGHT = 4'd3,
      PH_SMOKE = 4'd4,
      PH_CTRL  = 4'd5,
      PH_RSV   = 4'd6,
      PH_TAIL  = 4'd7,
      PH_CRC   = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      ST_BUSY          = 3'd0,
      ST_SECTOR_OK     = 3'd1,
      ST_END_OF_STREAM = 3'd2,
      ST_FORMAT_ERROR  = 3'd3,
      ST_NOT_READY     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ROUTE_DISCARD = 2'd0,
      ROUTE_AUDIO   = 2'd1,
      ROUTE_LIGHT   = 2'd2,
      ROUTE_SMOKE   = 2'd3
   } route_type;

   typedef struct packed {
      logic [31:0] header_word;
      logic [15:0] trailer_word;
      logic        byte_addressed_card;
      logic [15:0] token_wait_limit;
      logic [31:0] start_address;
      logic        addr_load;
   } cfg_type;

   typedef struct packed {
      route_type   route;
      logic [7:0]  payload;
      status_type  status;
      logic        lamp_line;
      logic        aux_line;
      logic        amp_enable_n;
      logic [31:0] next_address;
   } rsp_type;

endpackage

FILE: rtl/core/sfd_csr.sv
// ----------------------------------------------------------------------------
// sfd_csr
// configuration registers, written one beat at a time from the csr channel
// ----------------------------------------------------------------------------
module sfd_csr
   import sfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data,
   output cfg_type                cfg
);

   logic [31:0] header_ff;
   logic [15:0] trailer_ff;
   logic        byte_addr_ff;
   logic [15:0] wait_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff     <= '0;
         trailer_ff    <= '0;
         byte_addr_ff  <= 1'b1;
         wait_limit_ff <= WAIT_LIMIT_RESET;
      end else if (csr_write) begin
         // the start address goes straight into the parser's running address
         case (csr_index_type'(csr_index))
            CSR_HEADER_WORD:  header_ff     <= csr_data;
            CSR_TRAILER_WORD: trailer_ff    <= csr_data[15:0];
            CSR_BYTE_ADDR:    byte_addr_ff  <= csr_data[0];
            CSR_WAIT_LIMIT:   wait_limit_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.header_word         = header_ff;
      cfg.trailer_word        = trailer_ff;
      cfg.byte_addressed_card = byte_addr_ff;
      cfg.token_wait_limit    = wait_limit_ff;
      cfg.start_address       = csr_data;
      // running address takes the start address on the same beat
      cfg.addr_load           = csr_write && (csr_index_type'(csr_index) == CSR_START_ADDR);
   end

endmodule

FILE: rtl/core/sfd_parser.sv
// ----------------------------------------------------------------------------
// sfd_parser
// per-byte frame parser: token hunt, header, routing, control, tail and crc
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfd_parser
   import sfd_pkg::*;
#(
   parameter int AUDIO_BYTES    = AUDIO_BYTES_DEFAULT,
   parameter int LIGHT_BYTES    = LIGHT_BYTES_DEFAULT,
   parameter int SMOKE_BYTES    = SMOKE_BYTES_DEFAULT,
   parameter int RESERVED_BYTES = RESERVED_BYTES_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] card_byte,
   input  cfg_type    cfg,
   output rsp_type    result
);

   localparam int MAX_AB  = (AUDIO_BYTES > LIGHT_BYTES) ? AUDIO_BYTES : LIGHT_BYTES;
   localparam int MAX_SR  = (SMOKE_BYTES > RESERVED_BYTES) ? SMOKE_BYTES : RESERVED_BYTES;
   localparam int MAX_ABS = (MAX_AB > MAX_SR) ? MAX_AB : MAX_SR;
   localparam int MAX_LEN = (MAX_ABS > 4) ? MAX_ABS : 4;
   localparam int POS_W   = $clog2(MAX_LEN);

   localparam logic [POS_W-1:0] HEAD_LAST  = POS_W'(3);
   localparam logic [POS_W-1:0] PAIR_LAST  = POS_W'(1);
   localparam logic [POS_W-1:0] AUDIO_LAST = POS_W'(AUDIO_BYTES - 1);
   localparam logic [POS_W-1:0] LIGHT_LAST = POS_W'(LIGHT_BYTES - 1);
   localparam logic [POS_W-1:0] SMOKE_LAST = POS_W'(SMOKE_BYTES - 1);
   localparam logic [POS_W-1:0] RSV_LAST   =
      POS_W'((RESERVED_BYTES == 0) ? 0 : RESERVED_BYTES - 1);

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in, pos_inc;
   logic [15:0]      idle_ff, idle_in, idle_inc;
   logic [31:0]      head_ff, head_in, head_shifted;
   logic [15:0]      tail_ff, tail_in, tail_shifted;
   logic [31:0]      addr_ff, addr_in;
   logic [2:0]       ctrl_ff, ctrl_in;

   assign pos_inc      = pos_ff + 1'b1;
   assign idle_inc     = idle_ff + 16'd1;
   assign head_shifted = {head_ff[23:0], card_byte};
   assign tail_shifted = {tail_ff[7:0], card_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= '0;
         idle_ff  <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         addr_ff  <= START_ADDR_RESET;
         ctrl_ff  <= '0;
      end else begin
         if (step) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            idle_ff  <= idle_in;
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            ctrl_ff  <= ctrl_in;
         end
         if (cfg.addr_load) begin
            addr_ff <= cfg.start_address;
         end else if (step) begin
            addr_ff <= addr_in;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      idle_in  = idle_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      addr_in  = addr_ff;
      ctrl_in  = ctrl_ff;
      result.route   = ROUTE_DISCARD;
      result.payload = '0;
      result.status  = ST_BUSY;

      case (phase_ff)
         PH_HUNT: begin
            if (card_byte == DATA_TOKEN) begin
               phase_in = PH_HEAD;
               pos_in   = '0;
               idle_in  = '0;
               head_in  = '0;
            end else if (card_byte == IDLE_BYTE) begin
               // a zero limit behaves as one since any count reaches it
               if (idle_inc >= cfg.token_wait_limit) begin
                  result.status = ST_NOT_READY;
                  idle_in       = '0;
               end else begin
                  idle_in = idle_inc;
               end
            end else begin
               result.status = ST_NOT_READY;
               idle_in       = '0;
            end
         end
         PH_HEAD: begin
            head_in = head_shifted;
            if (pos_ff == HEAD_LAST) begin
               pos_in = '0;
               if (head_shifted == END_HEADER) begin
                  result.status = ST_END_OF_STREAM;
                  phase_in      = PH_HUNT;
                  idle_in       = '0;
               end else if (head_shifted != cfg.header_word) begin
                  result.status = ST_FORMAT_ERROR;
                  phase_in      = PH_HUNT;
                  idle_in       = '0;
               end else begin
                  phase_in = PH_AUDIO;
               end
            end else begin
               pos_in = pos_inc;
            end
         end
         PH_AUDIO: begin
            result.route   = ROUTE_AUDIO;
            result.payload = card_byte;
            if (pos_ff == AUDIO_LAST) begin
               phase_in = PH_LIGHT;
               pos_in   = '0;
            end else begin
               pos_in = pos_inc;
            end
         end
         PH_LIGHT: begin
            result.route   = ROUTE_LIGHT;
            result.payload = card_byte;
            if (pos_ff == LIGHT_LAST) begin
               phase_in = PH_SMOKE;
               pos_in   = '0;
            end else begin
               pos_in = pos_inc;
            end
         end
         PH_SMOKE: begin
            result.route   = ROUTE_SMOKE;
            result.payload = card_byte;
            if (pos_ff == SMOKE_LAST) begin
               phase_in = PH_CTRL;
               pos_in   = '0;
            end else begin
               pos_in = pos_inc;
            end
         end
         PH_CTRL: begin
            ctrl_in = card_byte[2:0];
            pos_in  = '0;
            if (RESERVED_BYTES > 0) begin
               phase_in = PH_RSV;
            end else begin
               phase_in = PH_TAIL;
               tail_in  = '0;
            end
         end
         PH_RSV: begin
            if (pos_ff == RSV_LAST) begin
               phase_in = PH_TAIL;
               pos_in   = '0;
               tail_in  = '0;
            end else begin
               pos_in = pos_inc;
            end
         end
         PH_TAIL: begin
            tail_in = tail_shifted;
            if (pos_ff == PAIR_LAST) begin
               pos_in = '0;
               if (tail_shifted != cfg.trailer_word) begin
                  result.status = ST_FORMAT_ERROR;
                  phase_in      = PH_HUNT;
                  idle_in       = '0;
               end else begin
                  phase_in = PH_CRC;
               end
            end else begin
               pos_in = pos_inc;
            end
         end
         PH_CRC: begin
            if (pos_ff == PAIR_LAST) begin
               addr_in       = addr_ff + (cfg.byte_addressed_card ? 32'(BLOCK_BYTES) : 32'd1);
               result.status = ST_SECTOR_OK;
               phase_in      = PH_HUNT;
               pos_in        = '0;
               idle_in       = '0;
            end else begin
               pos_in = pos_inc;
            end
         end
         default: begin
            phase_in = PH_HUNT;
            pos_in   = '0;
            idle_in  = '0;
         end
      endcase

      result.lamp_line    = ctrl_in[0];
      result.aux_line     = ctrl_in[1];
      result.amp_enable_n = ~ctrl_in[2];
      result.next_address = addr_in;
   end

   // every outcome other than busy sends the parser back to hunting
   `SFD_ASSERT_NEXT(a_outcome_hunts, clock, reset, step && (result.status != ST_BUSY), phase_ff == PH_HUNT, "outcome beat did not return to hunting")
   // routed bytes only come from the payload phases
   `SFD_ASSERT(a_route_busy, clock, reset, (result.route == ROUTE_DISCARD) || (result.status == ST_BUSY), "routed byte carried a status")

endmodule

FILE: rtl/core/sfd_rsp_buf.sv
// ----------------------------------------------------------------------------
// sfd_rsp_buf
// two-entry result buffer: output register plus skid stage
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfd_rsp_buf
   import sfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    push_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    head_valid_ff, skid_valid_ff;
   rsp_type head_ff, skid_ff;
   logic    pop;

   assign pop        = head_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;
   assign out_valid  = head_valid_ff;
   assign out_data   = head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else if (!push) begin
            head_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (head_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            head_valid_ff <= 1'b1;
         end
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_valid_ff) begin
            head_ff <= skid_ff;
         end else if (push) begin
            head_ff <= push_data;
         end
      end else if (push) begin
         if (head_valid_ff) begin
            skid_ff <= push_data;
         end else begin
            head_ff <= push_data;
         end
      end
   end

   `SFD_ASSERT(a_skid_needs_head, clock, reset, !skid_valid_ff || head_valid_ff, "skid entry held without head entry")
   `SFD_ASSERT_NEXT(a_stall_fills_skid, clock, reset, push && head_valid_ff && !out_ready, skid_valid_ff, "stalled beat not parked in skid stage")

endmodule

FILE: rtl/core/sector_frame_demultiplexer_core.sv
// ----------------------------------------------------------------------------
// sector_frame_demultiplexer_core
// Each card byte accepted on the req channel yields exactly one result beat
// on the rsp channel, from the result buffer's registered head. The core
// takes one byte every cycle while the buffer has room: the parser updates
// its phase, counters and shift registers once per byte, and the two-entry
// result buffer keeps the req side moving for one beat while the rsp side
// stalls. The result carries routing, status, the latched control lines
// and the running sector address. Configuration writes on the csr channel
// are taken (csr_ready is always high) and should be made while no byte is
// in flight; writing the start address also reloads the running address.
// ----------------------------------------------------------------------------
module sector_frame_demultiplexer_core
   import sfd_pkg::*;
#(
   parameter int AUDIO_BYTES    = AUDIO_BYTES_DEFAULT,
   parameter int LIGHT_BYTES    = LIGHT_BYTES_DEFAULT,
   parameter int SMOKE_BYTES    = SMOKE_BYTES_DEFAULT,
   parameter int RESERVED_BYTES = RESERVED_BYTES_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_card_byte,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_route,
   output logic [7:0]             rsp_payload,
   output logic [2:0]             rsp_status,
   output logic                   rsp_lamp_line,
   output logic                   rsp_aux_line,
   output logic                   rsp_amp_enable_n,
   output logic [31:0]            rsp_next_address,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   cfg_type cfg;
   rsp_type step_result, rsp_data;
   logic    req_beat, csr_beat;

   assign csr_ready = 1'b1;
   assign csr_beat  = csr_valid && csr_ready;
   assign req_beat  = req_valid && req_ready;

   sfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_beat),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sfd_parser #(
      .AUDIO_BYTES    (AUDIO_BYTES),
      .LIGHT_BYTES    (LIGHT_BYTES),
      .SMOKE_BYTES    (SMOKE_BYTES),
      .RESERVED_BYTES (RESERVED_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (req_beat),
      .card_byte (req_card_byte),
      .cfg       (cfg),
      .result    (step_result)
   );

   sfd_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (req_beat),
      .push_data  (step_result),
      .push_ready (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (rsp_data)
   );

   assign rsp_route        = rsp_data.route;
   assign rsp_payload      = rsp_data.payload;
   assign rsp_status       = rsp_data.status;
   assign rsp_lamp_line    = rsp_data.lamp_line;
   assign rsp_aux_line     = rsp_data.aux_line;
   assign rsp_amp_enable_n = rsp_data.amp_enable_n;
   assign rsp_next_address = rsp_data.next_address;

endmodule
